// ===== rtl/core/stack_opcode_engine_defines.svh =====
// Assertion helpers for the stack engine RTL.
`ifndef STACK_OPCODE_ENGINE_DEFINES_SVH
`define STACK_OPCODE_ENGINE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SOE_ASSERT_NOW(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SOE_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/soe_pkg.sv =====
`timescale 1ns / 1ps

package soe_pkg;

  localparam int STACK_DEPTH_DEF = 256;
  localparam int DATA_W          = 32;
  localparam int OP_W            = 3;
  localparam int ST_W            = 3;
  localparam int DEPTH_OUT_W     = 9;

  // opcodes
  localparam logic [OP_W-1:0] OP_PUSH = 3'd0;
  localparam logic [OP_W-1:0] OP_PEEK = 3'd1;
  localparam logic [OP_W-1:0] OP_POP  = 3'd2;
  localparam logic [OP_W-1:0] OP_SWAP = 3'd3;
  localparam logic [OP_W-1:0] OP_ADD  = 3'd4;

  // status codes
  localparam logic [ST_W-1:0] ST_OK         = 3'd0;
  localparam logic [ST_W-1:0] ST_FULL       = 3'd1;
  localparam logic [ST_W-1:0] ST_EMPTY_PEEK = 3'd2;
  localparam logic [ST_W-1:0] ST_EMPTY_POP  = 3'd3;
  localparam logic [ST_W-1:0] ST_SHORT_SWAP = 3'd4;
  localparam logic [ST_W-1:0] ST_SHORT_ADD  = 3'd5;

  // what a cell loads on the next edge
  typedef enum logic [1:0] {
    MV_HOLD,
    MV_FROM_UP,
    MV_FROM_DOWN
  } soe_move_t;

  // per-cycle command from the control block to the cell row
  typedef struct packed {
    soe_move_t head0;   // top cell
    soe_move_t head1;   // second cell
    soe_move_t body;    // all deeper cells
    logic      add_sel; // top cell takes the sum instead of cell 1
  } soe_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0]          opcode;
    logic signed [DATA_W-1:0] push_value;
  } soe_in_t;

  typedef struct packed {
    logic [ST_W-1:0]          status;
    logic signed [DATA_W-1:0] top_value;
    logic [DEPTH_OUT_W-1:0]   stack_depth;
  } soe_out_t;

endpackage

// ===== rtl/core/soe_stream_if.sv =====
`timescale 1ns / 1ps

interface soe_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/soe_cell.sv =====
`timescale 1ns / 1ps

module soe_cell (
  input  logic                              clk,
  input  soe_pkg::soe_move_t                move,
  input  logic [soe_pkg::DATA_W-1:0]        up_data,
  input  logic [soe_pkg::DATA_W-1:0]        down_data,
  output logic [soe_pkg::DATA_W-1:0]        data_r
);
  import soe_pkg::*;

  logic [DATA_W-1:0] data_nxt;

  always_comb begin
    unique case (move)
      MV_FROM_UP:   data_nxt = up_data;
      MV_FROM_DOWN: data_nxt = down_data;
      MV_HOLD:      data_nxt = data_r;
      default:      data_nxt = data_r;
    endcase
  end

  // entry payload, no reset: only entries below the count are ever shown
  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule

// ===== rtl/core/soe_ctrl.sv =====
`timescale 1ns / 1ps

module soe_ctrl #(
  parameter int STACK_DEPTH = soe_pkg::STACK_DEPTH_DEF,
  parameter int CW          = $clog2(STACK_DEPTH + 1)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     accept,
  input  logic [soe_pkg::OP_W-1:0] opcode,
  output soe_pkg::soe_cmd_t        cmd,
  output logic [soe_pkg::ST_W-1:0] status,
  output logic [CW-1:0]            count_nxt,
  output logic [CW-1:0]            count_r
);
  import soe_pkg::*;

  localparam logic [CW-1:0] FULL_CNT = CW'(STACK_DEPTH);
  localparam logic [CW-1:0] ONE_CNT  = CW'(1);

  logic      is_empty;
  logic      is_short;
  logic      is_full;
  soe_cmd_t  cmd_op;
  logic [CW-1:0] count_op;

  assign is_empty = (count_r == '0);
  assign is_short = (count_r <= ONE_CNT);
  assign is_full  = (count_r == FULL_CNT);

  always_comb begin
    cmd_op   = '{head0: MV_HOLD, head1: MV_HOLD, body: MV_HOLD, add_sel: 1'b0};
    count_op = count_r;
    status   = ST_OK;
    unique case (opcode)
      OP_PUSH: begin
        if (is_full) begin
          status = ST_FULL;
        end else begin
          cmd_op   = '{head0: MV_FROM_UP, head1: MV_FROM_UP, body: MV_FROM_UP,
                       add_sel: 1'b0};
          count_op = count_r + ONE_CNT;
        end
      end
      OP_PEEK: begin
        if (is_empty) status = ST_EMPTY_PEEK;
      end
      OP_POP: begin
        if (is_empty) begin
          status = ST_EMPTY_POP;
        end else begin
          cmd_op   = '{head0: MV_FROM_DOWN, head1: MV_FROM_DOWN, body: MV_FROM_DOWN,
                       add_sel: 1'b0};
          count_op = count_r - ONE_CNT;
        end
      end
      OP_SWAP: begin
        if (is_short) begin
          status = ST_SHORT_SWAP;
        end else begin
          cmd_op = '{head0: MV_FROM_DOWN, head1: MV_FROM_UP, body: MV_HOLD,
                     add_sel: 1'b0};
        end
      end
      OP_ADD: begin
        if (is_short) begin
          status = ST_SHORT_ADD;
        end else begin
          // top takes the sum, everything below moves up one place
          cmd_op   = '{head0: MV_FROM_DOWN, head1: MV_FROM_DOWN, body: MV_FROM_DOWN,
                       add_sel: 1'b1};
          count_op = count_r - ONE_CNT;
        end
      end
      default: begin
        // unused opcodes: no operation
      end
    endcase
  end

  always_comb begin
    if (accept) begin
      cmd       = cmd_op;
      count_nxt = count_op;
    end else begin
      cmd       = '{head0: MV_HOLD, head1: MV_HOLD, body: MV_HOLD, add_sel: 1'b0};
      count_nxt = count_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

endmodule

// ===== rtl/core/stack_opcode_engine.sv =====
`timescale 1ns / 1ps
// Channel  Dir  Payload                                 Transfer
// -------  ---  --------------------------------------  -------------------
// in_ch    in   opcode[2:0], push_value[31:0] signed    valid && ready
// out_ch   out  status[2:0], top_value[31:0] signed,    valid && ready
//               stack_depth[8:0]
//
// One item per cycle unless out_ch stalls: every opcode reads at most the top
// two cells, so the shift row, the count register and one 32-bit adder finish
// it. A transfer in is answered in the next cycle by a result in the output
// register. in_ch.ready drops only in reset or while that register holds a
// result that out_ch has not taken; a result taken and a new item in can
// share a cycle. Synchronous active-low reset clears the entry count and the
// output valid; the cell row holds no reset and needs no clearing pass.

`include "stack_opcode_engine_defines.svh"

module stack_opcode_engine #(
  parameter int STACK_DEPTH = soe_pkg::STACK_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  soe_stream_if.sink   in_ch,
  soe_stream_if.source out_ch
);
  import soe_pkg::*;

  // count holds 0..STACK_DEPTH
  localparam int CW = $clog2(STACK_DEPTH + 1);

  logic              in_ready;
  logic              accept;
  soe_cmd_t          cmd;
  logic [ST_W-1:0]   status_nxt;
  logic [CW-1:0]     count_nxt;
  logic [CW-1:0]     count_r;

  // cell 0 is the top of the stack, higher indexes lie deeper
  logic [DATA_W-1:0] cell_q [STACK_DEPTH];
  logic [DATA_W-1:0] push_data;
  logic [DATA_W-1:0] top_sum;
  logic [DATA_W-1:0] head_down;

  // output register
  logic              out_valid_r;
  logic [ST_W-1:0]   out_status_r;
  logic [CW-1:0]     out_count_r;
  logic [CW+DEPTH_OUT_W-1:0] depth_ext;
  soe_out_t          out_pl;

  // Room for a new item out of reset whenever the output register is free or drains now.
  assign in_ready    = rst_n && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = in_ready;
  assign accept      = in_ch.valid && in_ready;

  soe_ctrl #(
    .STACK_DEPTH (STACK_DEPTH),
    .CW          (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .opcode    (in_ch.data.opcode),
    .cmd       (cmd),
    .status    (status_nxt),
    .count_nxt (count_nxt),
    .count_r   (count_r)
  );

  assign push_data = in_ch.data.push_value;
  // wrapping sum of the top two entries
  assign top_sum   = cell_q[0] + cell_q[1];
  assign head_down = cmd.add_sel ? top_sum : cell_q[1];

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    soe_move_t         mv;
    logic [DATA_W-1:0] up_d;
    logic [DATA_W-1:0] down_d;

    if (i == 0) begin : g_top
      assign mv     = cmd.head0;
      assign up_d   = push_data;
      assign down_d = head_down;
    end else begin : g_rest
      if (i == 1) begin : g_second
        assign mv = cmd.head1;
      end else begin : g_body
        assign mv = cmd.body;
      end
      assign up_d = cell_q[i-1];
      if (i == STACK_DEPTH - 1) begin : g_bottom
        // nothing below the bottom cell; what it loads on a pop is never read
        assign down_d = cell_q[i];
      end else begin : g_mid
        assign down_d = cell_q[i+1];
      end
    end

    soe_cell u_cell (
      .clk       (clk),
      .move      (mv),
      .up_data   (up_d),
      .down_data (down_d),
      .data_r    (cell_q[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_status_r <= status_nxt;
      out_count_r  <= count_nxt;
    end
  end

  // The top cell cannot move while a result waits, since no item enters then,
  // so it is read straight from the row.
  assign depth_ext = {{DEPTH_OUT_W{1'b0}}, out_count_r};

  always_comb begin
    out_pl.status      = out_status_r;
    out_pl.top_value   = (out_count_r == '0) ? '0 : cell_q[0];
    out_pl.stack_depth = depth_ext[DEPTH_OUT_W-1:0];
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_pl;

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  `SOE_ASSERT_NOW(a_stall_blocks_in, clk, rst_n, out_valid_r && !out_ch.ready, !in_ready, "input taken while result stalled")
  `SOE_ASSERT_NOW(a_out_depth_live, clk, rst_n, out_valid_r, out_count_r == count_r, "shown depth differs from live count")
  `SOE_ASSERT_NEXT(a_reject_holds, clk, rst_n, accept && (status_nxt != ST_OK), count_r == $past(count_r), "rejected item changed the count")
  `SOE_ASSERT_NEXT(a_push_grows, clk, rst_n, accept && (in_ch.data.opcode == OP_PUSH) && (status_nxt == ST_OK), count_r == $past(count_r) + CW'(1), "push did not grow the stack")

endmodule
